// ----- src/tpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared codes, field widths and control types for the timestamp-ordered
// packet queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTES_W  = 24;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned TOTAL_W  = 30;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic put;
    logic get;
  } cell_ctrl_t;

endpackage

// ----- src/tpq_if.sv -----
// ----------------------------------------------------------------------------
// tpq_if
// Request and response channels of the packet queue (valid/ready).
// ----------------------------------------------------------------------------
interface tpq_req_if #(
  parameter int unsigned PTS_BITS = 33,
  parameter int unsigned TAG_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [tpq_pkg::OP_W-1:0]     operation;
  logic [PTS_BITS-1:0]          pts;
  logic [tpq_pkg::BYTES_W-1:0]  byte_size;
  logic [TAG_BITS-1:0]          packet_tag;

  modport source (output valid, operation, pts, byte_size, packet_tag, input ready);
  modport sink   (input valid, operation, pts, byte_size, packet_tag, output ready);
endinterface

interface tpq_rsp_if #(
  parameter int unsigned PTS_BITS = 33,
  parameter int unsigned TAG_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [tpq_pkg::STATUS_W-1:0] status;
  logic [PTS_BITS-1:0]          out_pts;
  logic [tpq_pkg::BYTES_W-1:0]  out_byte_size;
  logic [TAG_BITS-1:0]          out_packet_tag;
  logic [tpq_pkg::COUNT_W-1:0]  packet_count;
  logic [tpq_pkg::TOTAL_W-1:0]  byte_total;

  modport source (output valid, status, out_pts, out_byte_size, out_packet_tag,
                  packet_count, byte_total, input ready);
  modport sink   (input valid, status, out_pts, out_byte_size, out_packet_tag,
                  packet_count, byte_total, output ready);
endinterface

// ----- src/tpq_cell.sv -----
// ----------------------------------------------------------------------------
// tpq_cell
// One slot of the sorted shift row: holds a descriptor, compares it against
// the incoming timestamp and shifts right on put or left on get.
// ----------------------------------------------------------------------------
module tpq_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned PTS_BITS = 33,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                        clk_i,
  input  tpq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [PTS_BITS-1:0]         new_pts_i,
  input  logic [tpq_pkg::BYTES_W-1:0] new_bytes_i,
  input  logic [TAG_BITS-1:0]         new_tag_i,
  input  logic                        left_ins_i,
  input  logic [PTS_BITS-1:0]         left_pts_i,
  input  logic [tpq_pkg::BYTES_W-1:0] left_bytes_i,
  input  logic [TAG_BITS-1:0]         left_tag_i,
  input  logic [PTS_BITS-1:0]         right_pts_i,
  input  logic [tpq_pkg::BYTES_W-1:0] right_bytes_i,
  input  logic [TAG_BITS-1:0]         right_tag_i,
  output logic                        ins_o,
  output logic [PTS_BITS-1:0]         pts_o,
  output logic [tpq_pkg::BYTES_W-1:0] bytes_o,
  output logic [TAG_BITS-1:0]         tag_o
);

  logic [PTS_BITS-1:0]         pts_q;
  logic [tpq_pkg::BYTES_W-1:0] bytes_q;
  logic [TAG_BITS-1:0]         tag_q;
  logic                        occupied;
  logic                        at_tail;

  // this slot moves on put when it holds a later timestamp or is the free tail
  assign occupied = count_i > CNT_W'(IDX);
  assign at_tail  = count_i == CNT_W'(IDX);
  assign ins_o    = (occupied && (pts_q > new_pts_i)) || at_tail;

  // slot update: insert, shift right, shift left or hold
  always_ff @(posedge clk_i) begin
    if (ctrl_i.put && ins_o) begin
      if (left_ins_i) begin
        pts_q   <= left_pts_i;
        bytes_q <= left_bytes_i;
        tag_q   <= left_tag_i;
      end else begin
        pts_q   <= new_pts_i;
        bytes_q <= new_bytes_i;
        tag_q   <= new_tag_i;
      end
    end else if (ctrl_i.get) begin
      pts_q   <= right_pts_i;
      bytes_q <= right_bytes_i;
      tag_q   <= right_tag_i;
    end
  end

  assign pts_o   = pts_q;
  assign bytes_o = bytes_q;
  assign tag_o   = tag_q;

endmodule

// ----- src/timestamp_ordered_packet_queue_unit.sv -----
// ----------------------------------------------------------------------------
// timestamp_ordered_packet_queue_unit
// Bounded queue of packet descriptors kept sorted by timestamp in a row of
// compare-and-shift cells; put, get earliest and clear.
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle while the response sink keeps up; every cell
//   compares against the new timestamp in parallel and the whole row shifts in the same cycle
// reset: entry count, byte total and response valid clear at once;
//   slot contents are not cleared and are only read below the entry count
module timestamp_ordered_packet_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned PTS_BITS    = 33,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpq_req_if.sink   req_i,
  tpq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                        fire;
  logic                        is_put;
  logic                        is_get;
  logic                        is_clr;
  logic                        full;
  logic                        empty;
  tpq_pkg::cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            count_d;
  logic [tpq_pkg::TOTAL_W-1:0] total_q;
  logic [tpq_pkg::TOTAL_W-1:0] total_d;
  logic                        rsp_valid_q;
  logic [tpq_pkg::STATUS_W-1:0] status_d;

  logic                        cell_ins   [QUEUE_DEPTH];
  logic [PTS_BITS-1:0]         cell_pts   [QUEUE_DEPTH];
  logic [tpq_pkg::BYTES_W-1:0] cell_bytes [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]         cell_tag   [QUEUE_DEPTH];

  // handshake: response register frees when the sink takes it
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  // decode
  assign is_put = req_i.operation == tpq_pkg::OP_PUT;
  assign is_get = req_i.operation == tpq_pkg::OP_GET;
  assign is_clr = req_i.operation == tpq_pkg::OP_CLEAR;
  assign full   = count_q >= CNT_W'(QUEUE_DEPTH);
  assign empty  = count_q == '0;

  assign ctrl.put = fire && is_put && !full;
  assign ctrl.get = fire && is_get && !empty;

  // row of cells, left end holds the earliest entry
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                        l_ins;
    logic [PTS_BITS-1:0]         l_pts;
    logic [tpq_pkg::BYTES_W-1:0] l_bytes;
    logic [TAG_BITS-1:0]         l_tag;
    logic [PTS_BITS-1:0]         r_pts;
    logic [tpq_pkg::BYTES_W-1:0] r_bytes;
    logic [TAG_BITS-1:0]         r_tag;

    if (g == 0) begin : g_left_end
      assign l_ins   = 1'b0;
      assign l_pts   = req_i.pts;
      assign l_bytes = req_i.byte_size;
      assign l_tag   = req_i.packet_tag;
    end else begin : g_left
      assign l_ins   = cell_ins[g-1];
      assign l_pts   = cell_pts[g-1];
      assign l_bytes = cell_bytes[g-1];
      assign l_tag   = cell_tag[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_right_end
      assign r_pts   = req_i.pts;
      assign r_bytes = req_i.byte_size;
      assign r_tag   = req_i.packet_tag;
    end else begin : g_right
      assign r_pts   = cell_pts[g+1];
      assign r_bytes = cell_bytes[g+1];
      assign r_tag   = cell_tag[g+1];
    end

    tpq_cell #(
      .IDX      (g),
      .CNT_W    (CNT_W),
      .PTS_BITS (PTS_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .new_pts_i     (req_i.pts),
      .new_bytes_i   (req_i.byte_size),
      .new_tag_i     (req_i.packet_tag),
      .left_ins_i    (l_ins),
      .left_pts_i    (l_pts),
      .left_bytes_i  (l_bytes),
      .left_tag_i    (l_tag),
      .right_pts_i   (r_pts),
      .right_bytes_i (r_bytes),
      .right_tag_i   (r_tag),
      .ins_o         (cell_ins[g]),
      .pts_o         (cell_pts[g]),
      .bytes_o       (cell_bytes[g]),
      .tag_o         (cell_tag[g])
    );
  end

  // next count, byte total and status
  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    status_d = tpq_pkg::ST_DONE;
    if (is_put) begin
      if (full) begin
        status_d = tpq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
        total_d = total_q + tpq_pkg::TOTAL_W'(req_i.byte_size);
      end
    end else if (is_get) begin
      if (empty) begin
        status_d = tpq_pkg::ST_EMPTY;
      end else begin
        count_d = count_q - CNT_W'(1);
        total_d = total_q - tpq_pkg::TOTAL_W'(cell_bytes[0]);
      end
    end else if (is_clr) begin
      count_d = '0;
      total_d = '0;
    end
  end

  // queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_o.status       <= status_d;
      rsp_o.packet_count <= tpq_pkg::COUNT_W'(count_d);
      rsp_o.byte_total   <= total_d;
      if (ctrl.get) begin
        rsp_o.out_pts        <= cell_pts[0];
        rsp_o.out_byte_size  <= cell_bytes[0];
        rsp_o.out_packet_tag <= cell_tag[0];
      end else begin
        rsp_o.out_pts        <= '0;
        rsp_o.out_byte_size  <= '0;
        rsp_o.out_packet_tag <= '0;
      end
    end
  end

  assign rsp_o.valid = rsp_valid_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_o.valid)
    else $error("accepted request produced no response");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q) && $stable(total_q))
    else $error("queue state changed without a request");

  a_get_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_get && empty |=> rsp_o.status == tpq_pkg::ST_EMPTY
      && rsp_o.packet_count == '0)
    else $error("get on empty queue not reported");

endmodule

// ----- verif/tpq_order_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_order_checker
// Passive watcher of the packet queue channels. Keeps its own sorted copy of
// the held descriptors, works out the response each accepted request should
// produce, and compares every accepted response against the oldest one owed.
// ----------------------------------------------------------------------------
module tpq_order_checker
  import tpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned PTS_BITS    = 33,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpq_req_if          req_i,
  tpq_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned peak_fill_o,
  output int unsigned full_hits_o,
  output int unsigned empty_hits_o
);

  typedef struct {
    logic [PTS_BITS-1:0] stamp;
    logic [BYTES_W-1:0]  nbytes;
    logic [TAG_BITS-1:0] tag;
  } descriptor_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    descriptor_t         removed;
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total;
  } queue_rsp_t;

  // shadow of the queue contents, earliest first
  descriptor_t        held_q[$];
  logic [TOTAL_W-1:0] held_total = '0;
  queue_rsp_t         expected_rsp_q[$];

  int unsigned fail_count = 0;
  int unsigned peak_fill  = 0;
  int unsigned full_hits  = 0;
  int unsigned empty_hits = 0;

  // apply one request to the shadow queue and return the response it owes
  function automatic queue_rsp_t predict_queue_op(input logic [OP_W-1:0]     op,
                                                  input logic [PTS_BITS-1:0] stamp,
                                                  input logic [BYTES_W-1:0]  nbytes,
                                                  input logic [TAG_BITS-1:0] tag);
    queue_rsp_t  rsp;
    descriptor_t fresh;
    int unsigned slot;
    rsp.status  = ST_DONE;
    rsp.removed = '{default: '0};
    case (op)
      OP_PUT: begin
        if (held_q.size() >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          fresh = '{stamp, nbytes, tag};
          // walk back only past strictly later stamps, so equal stamps stay in order
          slot = held_q.size();
          while (slot > 0 && held_q[slot-1].stamp > stamp) slot--;
          held_q.insert(slot, fresh);
          held_total = held_total + TOTAL_W'(nbytes);
        end
      end
      OP_GET: begin
        if (held_q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.removed = held_q.pop_front();
          held_total  = held_total - TOTAL_W'(rsp.removed.nbytes);
        end
      end
      OP_CLEAR: begin
        held_q.delete();
        held_total = '0;
      end
      default: ;  // unused code leaves everything as it was
    endcase
    rsp.count = COUNT_W'(held_q.size());
    rsp.total = held_total;
    return rsp;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // requests first, so an answer in the same cycle as its request would still find its expectation
  always @(posedge clk_i) begin
    queue_rsp_t want;
    if (rst_ni) begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        expected_rsp_q.push_back(predict_queue_op(req_i.operation, req_i.pts,
                                                  req_i.byte_size, req_i.packet_tag));
        if (held_q.size() > peak_fill) peak_fill = held_q.size();
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with no request outstanding, status 0x%0h", $time,
                   rsp_i.status);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", want.status, rsp_i.status);
          check_field("out_pts", want.removed.stamp, rsp_i.out_pts);
          check_field("out_byte_size", want.removed.nbytes, rsp_i.out_byte_size);
          check_field("out_packet_tag", want.removed.tag, rsp_i.out_packet_tag);
          check_field("packet_count", want.count, rsp_i.packet_count);
          check_field("byte_total", want.total, rsp_i.byte_total);
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_EMPTY) empty_hits++;
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_rsp_q.size();
    peak_fill_o  <= peak_fill;
    full_hits_o  <= full_hits;
    empty_hits_o <= empty_hits;
  end

endmodule

// ----- verif/timestamp_ordered_packet_queue_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_packet_queue_unit_test
// Drives put, get and clear requests into the packet queue with random gaps
// and response back-pressure: a directed opening on field extremes and the
// empty and equal-stamp cases, then random phases of mixed traffic,
// fill-and-drain runs and equal-stamp bursts. The order checker judges.
// ----------------------------------------------------------------------------
module timestamp_ordered_packet_queue_unit_test;
  import tpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned PTS_BITS        = 33;
  localparam int unsigned TAG_BITS        = 16;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned RANDOM_ITEMS    = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT     = 800000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned peak_fill;
  int unsigned full_hits;
  int unsigned empty_hits;

  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned sent_total     = 0;
  int unsigned put_sent       = 0;
  int unsigned get_sent       = 0;
  int unsigned clear_sent     = 0;
  int unsigned reserved_sent  = 0;

  tpq_req_if #(.PTS_BITS(PTS_BITS), .TAG_BITS(TAG_BITS)) req_if ();
  tpq_rsp_if #(.PTS_BITS(PTS_BITS), .TAG_BITS(TAG_BITS)) rsp_if ();

  timestamp_ordered_packet_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PTS_BITS   (PTS_BITS),
    .TAG_BITS   (TAG_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  tpq_order_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PTS_BITS   (PTS_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_order_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .peak_fill_o (peak_fill),
    .full_hits_o (full_hits),
    .empty_hits_o(empty_hits)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("timestamp_ordered_packet_queue_unit verification failed");
      $finish;
    end
  end

  function automatic logic [PTS_BITS-1:0] draw_pts();
    int unsigned         pick;
    logic [PTS_BITS-1:0] stamp;
    pick  = $urandom_range(0, 99);
    stamp = PTS_BITS'({$urandom(), $urandom()});
    if (pick >= 40 && pick < 70) begin
      // tight range so equal stamps come up often
      stamp = PTS_BITS'($urandom_range(0, 15));
    end else if (pick >= 70 && pick < 85) begin
      stamp = {PTS_BITS{1'b1}} - PTS_BITS'($urandom_range(0, 15));
    end
    return stamp;
  endfunction

  function automatic logic [BYTES_W-1:0] draw_nbytes();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return BYTES_W'($urandom());
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // offer one request after an optional gap and wait for the handshake
  task automatic send_request(input logic [OP_W-1:0]     op,
                              input logic [PTS_BITS-1:0] stamp,
                              input logic [BYTES_W-1:0]  nbytes,
                              input logic [TAG_BITS-1:0] tag);
    int unsigned gap;
    int unsigned pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (pick < src_idle_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) gap = $urandom_range(1, 2);
      else if (pick < 95) gap = $urandom_range(3, 8);
      else gap = $urandom_range(20, 50);
    end
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.pts        <= stamp;
    req_if.byte_size  <= nbytes;
    req_if.packet_tag <= tag;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sent_total++;
    case (op)
      OP_PUT:   put_sent++;
      OP_GET:   get_sent++;
      OP_CLEAR: clear_sent++;
      default:  reserved_sent++;
    endcase
  endtask

  // any operation, random payload (ignored unless it is a put)
  task automatic send_random(input logic [OP_W-1:0] op, input logic [PTS_BITS-1:0] stamp);
    send_request(op, stamp, draw_nbytes(), TAG_BITS'($urandom()));
  endtask

  // response side: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned pick;
    stall_left = 0;
    hold_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < sink_stall_pct) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) stall_left = $urandom_range(1, 3);
          else if (pick < 95) stall_left = $urandom_range(4, 10);
          else stall_left = $urandom_range(15, 40);
          stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  // request side: reset, directed opening, random phases, verdict
  initial begin
    logic [PTS_BITS-1:0] base;
    logic [TAG_BITS-1:0] serial;
    int unsigned         burst;
    int unsigned         put_pct;
    int unsigned         pick;
    int unsigned         random_start;
    bit                  hold_off_done;
    serial        = '0;
    hold_off_done = 1'b0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_PUT;
    req_if.pts        <= '0;
    req_if.byte_size  <= '0;
    req_if.packet_tag <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 20;
    sink_stall_pct = 20;

    // empty queue: get, clear and the unused code
    send_random(OP_GET, draw_pts());
    send_random(OP_CLEAR, draw_pts());
    send_random(OP_RESERVED, draw_pts());
    // extremes of every field, equal stamps at both ends
    send_request(OP_PUT, '1, '1, '1);
    send_request(OP_PUT, '0, '0, '0);
    send_request(OP_PUT, '1, 24'd1, 16'd1);
    send_request(OP_PUT, 33'h1_0000_0000, 24'h800000, 16'd2);
    send_request(OP_PUT, '0, 24'd5, 16'd3);
    send_random(OP_RESERVED, draw_pts());
    // drain in order, then one get too many
    repeat (6) send_random(OP_GET, draw_pts());
    // three equal stamps are put, then cleared before any get
    send_request(OP_PUT, 33'd7, 24'h00000A, 16'h000A);
    send_request(OP_PUT, 33'd7, 24'h00000B, 16'h000B);
    send_request(OP_PUT, 33'd7, 24'h00000C, 16'h000C);
    send_random(OP_CLEAR, draw_pts());
    send_random(OP_GET, draw_pts());
    // alternating bit patterns
    send_request(OP_PUT, 33'h1_5555_5555, 24'hAAAAAA, 16'h5555);
    send_request(OP_PUT, 33'h0_AAAA_AAAA, 24'h555555, 16'hAAAA);
    send_random(OP_GET, draw_pts());
    send_random(OP_GET, draw_pts());

    random_start = sent_total;
    while (sent_total < random_start + RANDOM_ITEMS) begin
      src_idle_pct   = pick_idle_pct();
      sink_stall_pct = pick_idle_pct();

      // long response hold-off while requests keep coming back to back
      if (!hold_off_done && sent_total >= random_start + RANDOM_ITEMS / 2) begin
        hold_off_done = 1'b1;
        src_idle_pct  = 0;
        hold_off_req  = 1'b1;
        repeat (48) send_random(OP_PUT, draw_pts());
      end

      case ($urandom_range(0, 9))
        // fill past full, then drain past empty
        0, 1: begin
          send_random(OP_CLEAR, draw_pts());
          burst = QUEUE_DEPTH + $urandom_range(1, 5);
          repeat (burst) send_random(OP_PUT, draw_pts());
          repeat (burst) send_random(OP_GET, draw_pts());
        end
        // burst of near-equal stamps with serial tags
        2: begin
          base  = draw_pts();
          burst = $urandom_range(4, 20);
          repeat (burst) begin
            send_request(OP_PUT, base + PTS_BITS'($urandom_range(0, 2)), draw_nbytes(),
                         serial);
            serial++;
          end
          repeat (burst) send_random(OP_GET, draw_pts());
        end
        // mixed traffic with a drifting put share
        default: begin
          put_pct = $urandom_range(30, 70);
          repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < put_pct) send_random(OP_PUT, draw_pts());
            else if (pick < 96) send_random(OP_GET, draw_pts());
            else if (pick < 99) send_random(OP_CLEAR, draw_pts());
            else send_random(OP_RESERVED, draw_pts());
          end
        end
      endcase
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d requests: %0d put, %0d get, %0d clear, %0d unused code",
             sent_total, put_sent, get_sent, clear_sent, reserved_sent);
    $display("queue peaked at %0d entries; %0d puts refused as full, %0d gets found it empty",
             peak_fill, full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("timestamp_ordered_packet_queue_unit verification clean");
    end else begin
      $display("timestamp_ordered_packet_queue_unit verification failed");
    end
    $finish;
  end

endmodule
